// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; taken in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SEM_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("sobel edge assertion failed");

// next-cycle implication
`define SEM_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("sobel edge assertion failed");

`endif

// File: hdl/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude block.
// No dependencies.
package sem_pkg;

   localparam int CFG_W     = 11;
   localparam int PIX_W     = 8;
   localparam int RGB_W     = 3 * PIX_W;
   localparam int SENT_W    = 20;
   localparam int GRAD_W    = 12;
   localparam int SUM_W     = 21;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;
   localparam logic [SUM_W-1:0] SAT_SUM   = 21'd65281;
   localparam logic [PIX_W-1:0] EDGE_MAX  = 8'd255;
   localparam logic [PIX_W-1:0] ROOT_MSB  = 8'h80;

   typedef struct packed {
      logic load;
      logic step;
      logic grad;
      logic square;
      logic root;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic drop;
      logic has_result;
      logic root_last;
      logic out_free;
   } status_type;

endpackage

// File: hdl/sem_ram.sv
// Generic simple dual-port RAM, registered read.
// No dependencies.
module sem_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/sem_ctrl.sv
// Sequencer for the Sobel edge block: one item at a time.
// Depends on sem_pkg.
module sem_ctrl
   import sem_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_READ   = 6'b000010,
      ST_GRAD   = 6'b000100,
      ST_SQUARE = 6'b001000,
      ST_ROOT   = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            // an idle flush is taken and discarded
            if (req_valid && !status.drop) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.step = 1'b1;
            state_in = status.has_result ? ST_GRAD : ST_IDLE;
         end
         ST_GRAD: begin
            cmd.grad = 1'b1;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root = 1'b1;
            if (status.root_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// File: hdl/sem_datapath.sv
// Datapath: size registers, raster position, line stores, window,
// gradients, bit-serial square root per channel and the result register.
// Depends on sem_pkg and sem_ram.
module sem_datapath
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic                 req_type,
   input  logic [PIX_W-1:0]     req_pixel_blue,
   input  logic [PIX_W-1:0]     req_pixel_green,
   input  logic [PIX_W-1:0]     req_pixel_red,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [PIX_W-1:0]     rsp_edge_blue,
   output logic [PIX_W-1:0]     rsp_edge_green,
   output logic [PIX_W-1:0]     rsp_edge_red,
   output logic                 rsp_frame_last,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_write_data
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 4);

   // size registers
   logic [CFG_W-1:0] width_ff, height_ff;
   logic [WW-1:0]    w_cl;
   logic [HW-1:0]    h_cl;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_RESET;
         height_ff <= CFG_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == REG_FRAME_WIDTH) begin
            width_ff <= csr_write_data;
         end else begin
            height_ff <= csr_write_data;
         end
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         w_cl = WW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_cl = WW'(MAX_WIDTH);
      end else begin
         w_cl = WW'(width_ff);
      end
      if (height_ff == '0) begin
         h_cl = HW'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_cl = HW'(MAX_HEIGHT);
      end else begin
         h_cl = HW'(height_ff);
      end
   end

   // raster position
   logic [CW-1:0]     col_ff, ce_ff, ce_in;
   logic [RW-1:0]     row_ff, re_ff, re_in;
   logic [SENT_W-1:0] sent_ff;
   logic [RGB_W-1:0]  pix_ff;
   logic              col_wrap;

   always_comb begin
      col_wrap = 32'(col_ff) >= 32'(w_cl);
      ce_in    = col_wrap ? '0 : col_ff;
      re_in    = col_wrap ? row_ff + RW'(1) : row_ff;
   end

   assign status.drop = req_type && (col_ff == '0) && (row_ff == '0) && (sent_ff == '0);

   // line stores
   logic [RGB_W-1:0] up_rd, mid_rd;

   sem_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (cmd.step),
      .wr_addr (ce_ff),
      .wr_data (mid_rd),
      .rd_addr (ce_in),
      .rd_data (up_rd)
   );

   sem_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_middle (
      .clock   (clock),
      .wr_en   (cmd.step),
      .wr_addr (ce_ff),
      .wr_data (pix_ff),
      .rd_addr (ce_in),
      .rd_data (mid_rd)
   );

   // centre of the window and its border masks
   logic          have;
   logic [RW-1:0] cr;
   logic [CW-1:0] cc;
   logic [CW-1:0] ncol;
   logic [RW-1:0] nrow;
   logic          last, restart;

   always_comb begin
      if (ce_ff != '0) begin
         have = re_ff >= RW'(1);
         cr   = re_ff - RW'(1);
         cc   = ce_ff - CW'(1);
      end else begin
         have = re_ff >= RW'(2);
         cr   = re_ff - RW'(2);
         cc   = CW'(w_cl - WW'(1));
      end
      if (32'(ce_ff) + 1 >= 32'(w_cl)) begin
         ncol = '0;
         nrow = re_ff + RW'(1);
      end else begin
         ncol = ce_ff + CW'(1);
         nrow = re_ff;
      end
      status.has_result = have && (32'(cr) < 32'(h_cl)) && (32'(cc) < 32'(w_cl));
      last    = (32'(cr) == 32'(h_cl) - 1) && (32'(cc) == 32'(w_cl) - 1);
      restart = !status.has_result && (32'(nrow) > 32'(h_cl) + 1);
   end

   logic [2:0] rok_ff, cok_ff;
   logic       last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         sent_ff <= '0;
      end else if (cmd.step) begin
         if ((status.has_result && last) || restart) begin
            col_ff  <= '0;
            row_ff  <= '0;
            sent_ff <= '0;
         end else begin
            col_ff <= ncol;
            row_ff <= nrow;
            if (status.has_result) begin
               sent_ff <= sent_ff + SENT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ce_ff  <= ce_in;
         re_ff  <= re_in;
         pix_ff <= req_type ? '0 : {req_pixel_red, req_pixel_green, req_pixel_blue};
      end
      if (cmd.step) begin
         rok_ff  <= {32'(cr) != 32'(h_cl) - 1, 1'b1, cr != '0};
         cok_ff  <= {32'(cc) != 32'(w_cl) - 1, 1'b1, cc != '0};
         last_ff <= last;
      end
   end

   // 3x3 window, column 2 newest
   logic [RGB_W-1:0] win_ff [3][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (cmd.step) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= up_rd;
         win_ff[1][2] <= mid_rd;
         win_ff[2][2] <= pix_ff;
      end
   end

   // root step counter, one-hot on the trial bit
   logic [PIX_W-1:0] bit_ff;

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         bit_ff <= ROOT_MSB;
      end else if (cmd.root) begin
         bit_ff <= bit_ff >> 1;
      end
   end

   assign status.root_last = bit_ff[0];

   logic [PIX_W-1:0] edge_val [3];

   for (genvar ch = 0; ch < 3; ch++) begin : g_lane
      logic signed [GRAD_W-1:0] v [3][3];
      logic signed [GRAD_W-1:0] gx_in, gy_in, gx_ff, gy_ff;
      logic signed [2*GRAD_W-1:0] sqx, sqy;
      logic [SUM_W-1:0]   s_ff;
      logic [PIX_W-1:0]   n_ff, t;
      logic [2*PIX_W-1:0] nsq_ff, tsq;
      logic               rnd;
      logic [PIX_W:0]     val;

      always_comb begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               v[r][c] = (rok_ff[r] && cok_ff[c])
                         ? $signed({4'b0, win_ff[r][c][ch*PIX_W +: PIX_W]}) : '0;
            end
         end
         gx_in = v[0][2] - v[0][0] + ((v[1][2] - v[1][0]) <<< 1) + v[2][2] - v[2][0];
         gy_in = v[2][0] - v[0][0] + ((v[2][1] - v[0][1]) <<< 1) + v[2][2] - v[0][2];
         sqx   = gx_ff * gx_ff;
         sqy   = gy_ff * gy_ff;
         t     = n_ff | bit_ff;
         tsq   = {8'b0, t} * {8'b0, t};
         rnd   = s_ff > (SUM_W'(nsq_ff) + SUM_W'(n_ff));
         val   = {1'b0, n_ff} + (PIX_W + 1)'(rnd);
         if (s_ff >= SAT_SUM) begin
            edge_val[ch] = EDGE_MAX;
         end else begin
            edge_val[ch] = val[PIX_W] ? EDGE_MAX : val[PIX_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.grad) begin
            gx_ff <= gx_in;
            gy_ff <= gy_in;
         end
         if (cmd.square) begin
            s_ff   <= sqx[SUM_W-1:0] + sqy[SUM_W-1:0];
            n_ff   <= '0;
            nsq_ff <= '0;
         end else if (cmd.root) begin
            if (SUM_W'(tsq) <= s_ff) begin
               n_ff   <= t;
               nsq_ff <= tsq;
            end
         end
      end
   end

   // result register
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] blue_ff, green_ff, red_ff;
   logic             flast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         blue_ff  <= edge_val[0];
         green_ff <= edge_val[1];
         red_ff   <= edge_val[2];
         flast_ff <= last_ff;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_edge_blue   = blue_ff;
   assign rsp_edge_green  = green_ff;
   assign rsp_edge_red    = red_ff;
   assign rsp_frame_last  = flast_ff;

endmodule

// File: hdl/sobel_edge_magnitude_rgb.sv
// Sobel 3x3 edge magnitude on an RGB raster stream, one pixel per beat. Each
// pixel beat is accepted, then goes through line store read-back and window
// shift; a beat that completes a result goes on through gradient, squaring,
// the bit-serial square root run in step on the three channels, and then the
// load of the output register, which waits for as long as a stalled result
// still holds that register. An idle flush is taken and discarded. The next
// beat is taken while a finished result waits in the output register.
// Results lag input by width+1 raster positions; send width+1 flush beats
// after the last pixel to drain the frame. The line stores come up unwritten
// and need no clearing pass.
module sobel_edge_magnitude_rgb
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_type,
   input  logic [PIX_W-1:0]     req_pixel_blue,
   input  logic [PIX_W-1:0]     req_pixel_green,
   input  logic [PIX_W-1:0]     req_pixel_red,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [PIX_W-1:0]     rsp_edge_blue,
   output logic [PIX_W-1:0]     rsp_edge_green,
   output logic [PIX_W-1:0]     rsp_edge_red,
   output logic                 rsp_frame_last,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_write_data
);

   cmd_type    cmd;
   status_type status;

   sem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sem_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_type         (req_type),
      .req_pixel_blue   (req_pixel_blue),
      .req_pixel_green  (req_pixel_green),
      .req_pixel_red    (req_pixel_red),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_edge_blue    (rsp_edge_blue),
      .rsp_edge_green   (rsp_edge_green),
      .rsp_edge_red     (rsp_edge_red),
      .rsp_frame_last   (rsp_frame_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

endmodule

// File: hdl/sem_checker.sv
// Port-level checker for the Sobel edge block, bound to the top level.
// Depends on sem_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sem_checker
   import sem_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 req_type,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [PIX_W-1:0]     rsp_edge_blue,
   input logic [PIX_W-1:0]     rsp_edge_green,
   input logic [PIX_W-1:0]     rsp_edge_red,
   input logic                 rsp_frame_last
);

   // an accepted pixel beat always leaves the block busy, stalling further requests
   `SEM_ASSERT_NEXT(a_pixel_busy, clock, reset, req_valid && !req_stall && !req_type, req_stall)

   // reset leaves the block empty and ready
   `SEM_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid && !req_stall)

   `SEM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   `SEM_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall,
      $stable(rsp_edge_blue) && $stable(rsp_edge_green) && $stable(rsp_edge_red)
      && $stable(rsp_frame_last))

endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_type       (req_type),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_edge_blue  (rsp_edge_blue),
   .rsp_edge_green (rsp_edge_green),
   .rsp_edge_red   (rsp_edge_red),
   .rsp_frame_last (rsp_frame_last)
);
